### sv/ntwa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the neighbor table with aging.
// No dependencies; used by the interfaces, the table and the checker.
package ntwa_pkg;

    localparam int MAC_W  = 48;
    localparam int TICK_W = 16;

    localparam logic [TICK_W-1:0] EXPIRY_RESET = 16'd1000;

    typedef enum logic [1:0] {
        REQ_UPDATE  = 2'd0,
        REQ_MAC_LKP = 2'd1,
        REQ_VID_LKP = 2'd2,
        REQ_TICK    = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;

    // One table entry as stored in the RAM.
    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  key_mac;
        logic [MAC_W-1:0]  peer_vid;
        logic [MAC_W-1:0]  own_mac;
        logic [MAC_W-1:0]  own_vid;
        logic [TICK_W-1:0] ticks_left;
    } t_entry;

    // Request word latched at accept.
    typedef struct packed {
        t_req_type        req_type;
        logic [MAC_W-1:0] neighbor_mac;
        logic [MAC_W-1:0] neighbor_vid;
        logic [MAC_W-1:0] local_mac;
        logic [MAC_W-1:0] local_vid;
    } t_req;

endpackage

### sv/ntwa_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on ntwa_pkg for field widths.
interface ntwa_req_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              req_type;
    logic [ntwa_pkg::MAC_W-1:0] neighbor_mac;
    logic [ntwa_pkg::MAC_W-1:0] neighbor_vid;
    logic [ntwa_pkg::MAC_W-1:0] local_mac;
    logic [ntwa_pkg::MAC_W-1:0] local_vid;

    modport source (output valid, req_type, neighbor_mac, neighbor_vid, local_mac,
                    local_vid, input ready);
    modport sink   (input valid, req_type, neighbor_mac, neighbor_vid, local_mac,
                    local_vid, output ready);
endinterface

interface ntwa_rsp_if;
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic                    table_full;
    logic [ntwa_pkg::MAC_W-1:0] found_neighbor_vid;
    logic [ntwa_pkg::MAC_W-1:0] found_local_mac;
    logic [ntwa_pkg::MAC_W-1:0] found_local_vid;

    modport source (output valid, hit, table_full, found_neighbor_vid, found_local_mac,
                    found_local_vid, input ready);
    modport sink   (input valid, hit, table_full, found_neighbor_vid, found_local_mac,
                    found_local_vid, output ready);
endinterface

interface ntwa_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ntwa_pkg::TICK_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### sv/ntwa_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ntwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### sv/neighbor_table_with_aging.sv
`timescale 1ns / 1ps
// Neighbor table with aging, keyed by neighbor MAC, stored in one RAM.
// Depends on ntwa_pkg, ntwa_if.sv and ntwa_ram.
//
// The table holds TABLE_ENTRIES entries in a single RAM with a registered
// read. Every request word walks the whole RAM once, one entry a cycle;
// an update then writes the chosen entry in a write step before the result
// word is presented. That sweep through the single RAM read port sets the
// rate; a new request word is taken only while the block is idle, and a
// previous result that is not yet taken holds the block in its final step.
// After reset the block clears the valid flag of every entry, one entry a
// cycle, before it takes the first request word; the expiry register can
// be written at any time, including then. An update refreshes a matching
// key or fills the lowest free entry and reloads its countdown; a new key
// with no free entry is dropped and flagged with table_full. A tick
// decrements every valid countdown and drops entries that reach zero.
// Lookups by MAC or by neighbor VID return the lowest-index valid match.
module neighbor_table_with_aging #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ntwa_req_if.sink          i_req,
    ntwa_rsp_if.source        o_rsp,
    ntwa_cfg_if.sink          i_cfg
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = $bits(ntwa_pkg::t_entry);
    localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);
    localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_ENTRIES - 1);

    // control state
    ntwa_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cnt;
    logic             r_pend;
    logic             r_match_ok;
    logic             r_free_ok;
    logic             r_out_valid;
    logic [ntwa_pkg::TICK_W-1:0] r_expiry;

    // payload
    ntwa_pkg::t_req              r_req;
    logic [IW-1:0]               r_pidx;
    logic [IW-1:0]               r_slot;
    logic [IW-1:0]               r_free;
    logic [ntwa_pkg::MAC_W-1:0]  r_fnd_vid;
    logic [ntwa_pkg::MAC_W-1:0]  r_fnd_lmac;
    logic [ntwa_pkg::MAC_W-1:0]  r_fnd_lvid;
    logic                        r_out_hit;
    logic                        r_out_full;
    logic [ntwa_pkg::MAC_W-1:0]  r_out_vid;
    logic [ntwa_pkg::MAC_W-1:0]  r_out_lmac;
    logic [ntwa_pkg::MAC_W-1:0]  r_out_lvid;

    // RAM ports
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    ntwa_pkg::t_entry ram_wdata;
    ntwa_pkg::t_entry ram_rdata;
    logic [EW-1:0]    ram_rdata_raw;

    logic in_acc, out_free, issue, key_hit, vid_hit, sel_hit, is_free;
    logic is_lookup;

    ntwa_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = ntwa_pkg::t_entry'(ram_rdata_raw);

    assign in_acc    = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign issue     = (r_state == ntwa_pkg::ST_SCAN) && (r_cnt != CNT_END);
    assign is_lookup = (r_req.req_type == ntwa_pkg::REQ_MAC_LKP) ||
                       (r_req.req_type == ntwa_pkg::REQ_VID_LKP);

    // Match tests on the word coming back from the RAM.
    assign key_hit = ram_rdata.valid && (ram_rdata.key_mac == r_req.neighbor_mac);
    assign vid_hit = ram_rdata.valid && (ram_rdata.peer_vid == r_req.neighbor_vid);
    assign is_free = !ram_rdata.valid;

    always_comb begin
        unique case (r_req.req_type)
            ntwa_pkg::REQ_UPDATE,
            ntwa_pkg::REQ_MAC_LKP: sel_hit = key_hit;
            ntwa_pkg::REQ_VID_LKP: sel_hit = vid_hit;
            default:               sel_hit = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ntwa_pkg::ST_CLEAR: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = ntwa_pkg::ST_IDLE;
                end
            end
            ntwa_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = ntwa_pkg::ST_SCAN;
                end
            end
            ntwa_pkg::ST_SCAN: begin
                // last read data is consumed at this same edge
                if (r_cnt == CNT_END) begin
                    n_state = (r_req.req_type == ntwa_pkg::REQ_UPDATE) ?
                              ntwa_pkg::ST_WRITE : ntwa_pkg::ST_DONE;
                end
            end
            ntwa_pkg::ST_WRITE: n_state = ntwa_pkg::ST_DONE;
            ntwa_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = ntwa_pkg::ST_IDLE;
                end
            end
            default: n_state = ntwa_pkg::ST_CLEAR;
        endcase
    end

    // outputs: RAM write port and handshakes
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt[IW-1:0];
        ram_wdata = '0;
        unique case (r_state)
            ntwa_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ntwa_pkg::ST_SCAN: begin
                // age the entry just read; write-back address trails the read
                ram_waddr = r_pidx;
                ram_wdata = ram_rdata;
                if (r_pend && (r_req.req_type == ntwa_pkg::REQ_TICK) && ram_rdata.valid) begin
                    ram_we = 1'b1;
                    if (ram_rdata.ticks_left <= ntwa_pkg::TICK_W'(1)) begin
                        ram_wdata.valid      = 1'b0;
                        ram_wdata.ticks_left = '0;
                    end else begin
                        ram_wdata.ticks_left = ram_rdata.ticks_left - ntwa_pkg::TICK_W'(1);
                    end
                end
            end
            ntwa_pkg::ST_WRITE: begin
                ram_we               = r_match_ok || r_free_ok;
                ram_waddr            = r_match_ok ? r_slot : r_free;
                ram_wdata.valid      = 1'b1;
                ram_wdata.key_mac    = r_req.neighbor_mac;
                ram_wdata.peer_vid   = r_req.neighbor_vid;
                ram_wdata.own_mac    = r_req.local_mac;
                ram_wdata.own_vid    = r_req.local_vid;
                ram_wdata.ticks_left = r_expiry;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign i_req.ready = (r_state == ntwa_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.hit                = r_out_hit;
    assign o_rsp.table_full         = r_out_full;
    assign o_rsp.found_neighbor_vid = r_out_vid;
    assign o_rsp.found_local_mac    = r_out_lmac;
    assign o_rsp.found_local_vid    = r_out_lvid;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ntwa_pkg::ST_CLEAR;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_match_ok  <= 1'b0;
            r_free_ok   <= 1'b0;
            r_out_valid <= 1'b0;
            r_expiry    <= ntwa_pkg::EXPIRY_RESET;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;

            if (i_cfg.valid && i_cfg.ready) begin
                r_expiry <= i_cfg.data;
            end

            // advance the sweep counter
            if (r_state == ntwa_pkg::ST_CLEAR) begin
                r_cnt <= (r_cnt == CNT_LAST) ? '0 : r_cnt + CW'(1);
            end else if (in_acc) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + CW'(1);
            end

            // track first match and first free entry
            if (in_acc) begin
                r_match_ok <= 1'b0;
                r_free_ok  <= 1'b0;
            end else if (r_pend) begin
                if (sel_hit) begin
                    r_match_ok <= 1'b1;
                end
                if (is_free) begin
                    r_free_ok <= 1'b1;
                end
            end

            // hold the result word until taken
            if ((r_state == ntwa_pkg::ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pidx <= r_cnt[IW-1:0];

        if (in_acc) begin
            r_req.req_type     <= ntwa_pkg::t_req_type'(i_req.req_type);
            r_req.neighbor_mac <= i_req.neighbor_mac;
            r_req.neighbor_vid <= i_req.neighbor_vid;
            r_req.local_mac    <= i_req.local_mac;
            r_req.local_vid    <= i_req.local_vid;
        end

        if (r_pend && !in_acc) begin
            if (sel_hit && !r_match_ok) begin
                r_slot     <= r_pidx;
                r_fnd_vid  <= ram_rdata.peer_vid;
                r_fnd_lmac <= ram_rdata.own_mac;
                r_fnd_lvid <= ram_rdata.own_vid;
            end
            if (is_free && !r_free_ok) begin
                r_free <= r_pidx;
            end
        end

        if ((r_state == ntwa_pkg::ST_DONE) && out_free) begin
            r_out_hit  <= r_match_ok;
            r_out_full <= (r_req.req_type == ntwa_pkg::REQ_UPDATE) && !r_match_ok && !r_free_ok;
            r_out_vid  <= (is_lookup && r_match_ok) ? r_fnd_vid  : '0;
            r_out_lmac <= (is_lookup && r_match_ok) ? r_fnd_lmac : '0;
            r_out_lvid <= (is_lookup && r_match_ok) ? r_fnd_lvid : '0;
        end
    end

endmodule

### sv/ntwa_checker.sv
`timescale 1ns / 1ps
// Port-level checker for neighbor_table_with_aging, attached by bind.
// Depends on ntwa_pkg widths only.
module ntwa_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_hit,
    input logic                       i_table_full,
    input logic [ntwa_pkg::MAC_W-1:0] i_found_vid,
    input logic [ntwa_pkg::MAC_W-1:0] i_found_lmac,
    input logic [ntwa_pkg::MAC_W-1:0] i_found_lvid
);

    logic [1:0] r_outst;
    logic       in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // count words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else if (in_acc && !out_acc) begin
            r_outst <= r_outst + 2'd1;
        end else if (out_acc && !in_acc) begin
            r_outst <= r_outst - 2'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_hit) &&
            $stable(i_found_vid))
        else $error("result word changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_outst != 2'd0)
        else $error("result word without a pending request");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outst != 2'd3)
        else $error("more than two words in flight");

    a_hit_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_hit && i_table_full))
        else $error("hit and table_full together");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_hit |-> (i_found_vid == '0) && (i_found_lmac == '0) &&
            (i_found_lvid == '0))
        else $error("found fields nonzero on a miss");

endmodule

bind neighbor_table_with_aging ntwa_checker u_ntwa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_hit        (o_rsp.hit),
    .i_table_full (o_rsp.table_full),
    .i_found_vid  (o_rsp.found_neighbor_vid),
    .i_found_lmac (o_rsp.found_local_mac),
    .i_found_lvid (o_rsp.found_local_vid)
);
